/* hdl/abis_pkg.sv */
`default_nettype none
package abis_pkg;

  // camera point width: signed, Q16.16 with headroom for R*p plus translation
  localparam int CW = 37;

  localparam logic signed [31:0] Q_ONE = 32'sd16384;

  localparam logic [16:0] COUNT_MAX = 17'h1FFFF;
  localparam logic [46:0] SCORE_MAX = 47'h7FFF_FFFF_FFFF;

  localparam logic [2:0] CFG_QUAT_W  = 3'd0;
  localparam logic [2:0] CFG_QUAT_X  = 3'd1;
  localparam logic [2:0] CFG_QUAT_Y  = 3'd2;
  localparam logic [2:0] CFG_QUAT_Z  = 3'd3;
  localparam logic [2:0] CFG_TRANS_X = 3'd4;
  localparam logic [2:0] CFG_TRANS_Y = 3'd5;
  localparam logic [2:0] CFG_TRANS_Z = 3'd6;
  localparam logic [2:0] CFG_SQ_THR  = 3'd7;

  typedef struct packed {
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [31:0] trans_x;
    logic signed [31:0] trans_y;
    logic signed [31:0] trans_z;
  } pose_t;

  // camera-frame point handed from front to back
  typedef struct packed {
    logic signed [CW-1:0] cam_x;
    logic signed [CW-1:0] cam_y;
    logic signed [CW-1:0] cam_z;
    logic signed [15:0]   bear_x;
    logic signed [15:0]   bear_y;
    logic signed [15:0]   bear_z;
    logic                 last;
  } item_t;

  function automatic logic signed [31:0] clamp_q(input logic signed [15:0] v);
    logic signed [31:0] e;
    e = 32'(v);
    if (e > Q_ONE) return Q_ONE;
    if (e < -Q_ONE) return -Q_ONE;
    return e;
  endfunction

endpackage
`default_nettype wire

/* hdl/abis_front.sv */
`default_nettype none
module abis_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [15:0]  bearing_x,
  input  logic signed [15:0]  bearing_y,
  input  logic signed [15:0]  bearing_z,
  input  logic signed [31:0]  point_x,
  input  logic signed [31:0]  point_y,
  input  logic signed [31:0]  point_z,
  input  logic                last_pair,
  input  abis_pkg::pose_t     pose,
  output abis_pkg::item_t     item,
  output logic                item_valid,
  input  logic                item_ready
);
  import abis_pkg::*;

  typedef enum logic [1:0] {F_IDLE, F_MUL, F_ACC, F_PUSH} fstate_t;

  fstate_t            state;
  logic [4:0]         step;
  logic [1:0]         row;
  logic [1:0]         col;
  logic signed [31:0] qp [10];
  logic signed [31:0] px, py, pz;
  logic signed [15:0] bx, by, bz;
  logic               last;
  logic signed [63:0] prod;
  logic signed [63:0] acc;
  logic signed [CW-1:0] cam [3];

  logic signed [31:0] qw, qx, qy, qz;
  logic signed [31:0] rm [3][3];
  logic signed [31:0] tv [3];
  logic signed [31:0] op_a, op_b, p_sel;
  logic signed [63:0] acc_sum;
  logic signed [63:0] acc_shr;

  assign qw = clamp_q(pose.quat_w);
  assign qx = clamp_q(pose.quat_x);
  assign qy = clamp_q(pose.quat_y);
  assign qz = clamp_q(pose.quat_z);

  // qp: ww xx yy zz xy wz xz wy yz wx
  always_comb begin
    rm[0][0] = qp[0] + qp[1] - qp[2] - qp[3];
    rm[0][1] = (qp[4] - qp[5]) <<< 1;
    rm[0][2] = (qp[6] + qp[7]) <<< 1;
    rm[1][0] = (qp[4] + qp[5]) <<< 1;
    rm[1][1] = qp[0] - qp[1] + qp[2] - qp[3];
    rm[1][2] = (qp[8] - qp[9]) <<< 1;
    rm[2][0] = (qp[6] - qp[7]) <<< 1;
    rm[2][1] = (qp[8] + qp[9]) <<< 1;
    rm[2][2] = qp[0] - qp[1] - qp[2] + qp[3];
  end

  assign tv[0] = pose.trans_x;
  assign tv[1] = pose.trans_y;
  assign tv[2] = pose.trans_z;

  always_comb begin
    case (col)
      2'd0:    p_sel = px;
      2'd1:    p_sel = py;
      default: p_sel = pz;
    endcase
  end

  always_comb begin
    case (step)
      5'd0:    begin op_a = qw; op_b = qw; end
      5'd1:    begin op_a = qx; op_b = qx; end
      5'd2:    begin op_a = qy; op_b = qy; end
      5'd3:    begin op_a = qz; op_b = qz; end
      5'd4:    begin op_a = qx; op_b = qy; end
      5'd5:    begin op_a = qw; op_b = qz; end
      5'd6:    begin op_a = qx; op_b = qz; end
      5'd7:    begin op_a = qw; op_b = qy; end
      5'd8:    begin op_a = qy; op_b = qz; end
      5'd9:    begin op_a = qw; op_b = qx; end
      default: begin op_a = rm[row][col]; op_b = p_sel; end
    endcase
  end

  assign acc_sum = acc + prod;
  assign acc_shr = acc_sum >>> 28;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      step  <= '0;
      row   <= '0;
      col   <= '0;
    end else begin
      case (state)
        F_IDLE: begin
          if (in_valid) begin
            bx    <= bearing_x;
            by    <= bearing_y;
            bz    <= bearing_z;
            px    <= point_x;
            py    <= point_y;
            pz    <= point_z;
            last  <= last_pair;
            step  <= '0;
            row   <= '0;
            col   <= '0;
            state <= F_MUL;
          end
        end
        F_MUL: begin
          prod  <= op_a * op_b;
          state <= F_ACC;
        end
        F_ACC: begin
          if (step < 5'd10) begin
            qp[step[3:0]] <= prod[31:0];
          end else begin
            acc <= (col == 2'd0) ? prod : acc_sum;
            if (col == 2'd2) begin
              cam[row] <= acc_shr[CW-1:0] + CW'(tv[row]);
              col      <= '0;
              row      <= row + 2'd1;
            end else begin
              col <= col + 2'd1;
            end
          end
          if (step == 5'd18) begin
            state <= F_PUSH;
          end else begin
            step  <= step + 5'd1;
            state <= F_MUL;
          end
        end
        F_PUSH: begin
          if (item_ready) state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  assign in_ready    = (state == F_IDLE);
  assign item_valid  = (state == F_PUSH);
  assign item.cam_x  = cam[0];
  assign item.cam_y  = cam[1];
  assign item.cam_z  = cam[2];
  assign item.bear_x = bx;
  assign item.bear_y = by;
  assign item.bear_z = bz;
  assign item.last   = last;

endmodule
`default_nettype wire

/* hdl/abis_fifo.sv */
`default_nettype none
module abis_fifo (
  input  logic            clk,
  input  logic            rst,
  input  abis_pkg::item_t wr_item,
  input  logic            wr_valid,
  output logic            wr_ready,
  output abis_pkg::item_t rd_item,
  output logic            rd_valid,
  input  logic            rd_ready
);
  import abis_pkg::*;

  item_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push, pop;

  assign wr_ready = (fill != 2'd2);
  assign rd_valid = (fill != 2'd0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wr_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      if (push && !pop)      fill <= fill + 2'd1;
      else if (pop && !push) fill <= fill - 2'd1;
    end
  end

endmodule
`default_nettype wire

/* hdl/abis_back.sv */
`default_nettype none
module abis_back (
  input  logic            clk,
  input  logic            rst,
  input  abis_pkg::item_t item,
  input  logic            item_valid,
  output logic            item_ready,
  input  logic [30:0]     thr,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            is_inlier,
  output logic [30:0]     clipped_error,
  output logic [16:0]     inlier_count,
  output logic [46:0]     score_total,
  output logic            pass_done
);
  import abis_pkg::*;

  typedef enum logic [3:0] {
    B_IDLE, B_NORM, B_SQ_MUL, B_SQ_ACC, B_SQRT, B_DIV_INIT, B_DIV,
    B_D_MUL, B_D_ACC, B_ERR, B_DONE
  } bstate_t;

  bstate_t              state;
  logic signed [CW-1:0] cv [3];
  logic signed [15:0]   bb [3];
  logic                 last;
  logic [CW-1:0]        m;
  logic [1:0]           idx;
  logic [63:0]          s, sum, rt, bitv;
  logic signed [63:0]   prod;
  logic [30:0]          rem;
  logic [29:0]          divq;
  logic [4:0]           dcnt;
  logic [35:0]          err;
  logic [16:0]          count_accum;
  logic [46:0]          score_accum;

  logic [CW-1:0]        mag0, mag1, mag2, m01, m_in;
  logic signed [31:0]   cn, q32, u, dv, mul_a;
  logic [30:0]          cmag, n;
  logic [58:0]          numer;
  logic [31:0]          div_t, div_d;
  logic                 div_ge;
  logic [63:0]          trial;
  logic                 inl;
  logic [30:0]          clipped;
  logic [17:0]          cnt_sum;
  logic [47:0]          score_sum;
  logic [16:0]          cnt_sat;
  logic [46:0]          score_sat;

  function automatic logic [CW-1:0] mag(input logic signed [CW-1:0] v);
    return v[CW-1] ? CW'(-v) : CW'(v);
  endfunction

  assign mag0 = mag(item.cam_x);
  assign mag1 = mag(item.cam_y);
  assign mag2 = mag(item.cam_z);
  assign m01  = (mag0 > mag1) ? mag0 : mag1;
  assign m_in = (m01 > mag2) ? m01 : mag2;

  // after normalizing, the selected component fits 32 bits
  assign cn    = cv[idx][31:0];
  assign cmag  = cn[31] ? 31'(-cn) : cn[30:0];
  assign n     = rt[30:0];
  assign numer = {cmag, 28'b0} + 59'(n >> 1);

  assign div_t  = {rem, divq[29]};
  assign div_ge = div_t >= {1'b0, n};
  assign div_d  = div_t - {1'b0, n};

  assign q32   = {2'b00, divq};
  assign u     = cn[31] ? -q32 : q32;
  assign dv    = (32'(bb[idx]) <<< 14) - u;
  assign mul_a = (state == B_SQ_MUL) ? cn : dv;

  assign trial = rt + bitv;

  assign inl       = err < 36'(thr);
  assign clipped   = inl ? err[30:0] : thr;
  assign cnt_sum   = {1'b0, count_accum} + 18'(inl);
  assign score_sum = {1'b0, score_accum} + 48'(clipped);
  assign cnt_sat   = cnt_sum[17] ? COUNT_MAX : cnt_sum[16:0];
  assign score_sat = score_sum[47] ? SCORE_MAX : score_sum[46:0];

  assign item_ready = (state == B_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= B_IDLE;
      out_valid   <= 1'b0;
      count_accum <= '0;
      score_accum <= '0;
      idx         <= '0;
      dcnt        <= '0;
    end else begin
      if (out_valid && out_ready && state != B_DONE) out_valid <= 1'b0;
      case (state)
        B_IDLE: begin
          if (item_valid) begin
            cv[0] <= item.cam_x;
            cv[1] <= item.cam_y;
            cv[2] <= item.cam_z;
            bb[0] <= item.bear_x;
            bb[1] <= item.bear_y;
            bb[2] <= item.bear_z;
            last  <= item.last;
            m     <= m_in;
            s     <= '0;
            sum   <= '0;
            idx   <= '0;
            state <= B_NORM;
          end
        end
        B_NORM: begin
          // one bit a beat until the largest magnitude sits in [2^29, 2^30)
          if (m == '0) begin
            err   <= 36'(thr);
            state <= B_DONE;
          end else if (m[CW-1:30] != '0) begin
            cv[0] <= cv[0] >>> 1;
            cv[1] <= cv[1] >>> 1;
            cv[2] <= cv[2] >>> 1;
            m     <= m >> 1;
          end else if (m[CW-1:29] == '0) begin
            cv[0] <= cv[0] <<< 1;
            cv[1] <= cv[1] <<< 1;
            cv[2] <= cv[2] <<< 1;
            m     <= m << 1;
          end else begin
            state <= B_SQ_MUL;
          end
        end
        B_SQ_MUL: begin
          prod  <= mul_a * mul_a;
          state <= B_SQ_ACC;
        end
        B_SQ_ACC: begin
          s <= s + 64'(prod);
          if (idx == 2'd2) begin
            idx   <= '0;
            rt    <= '0;
            bitv  <= 64'h4000_0000_0000_0000;
            state <= B_SQRT;
          end else begin
            idx   <= idx + 2'd1;
            state <= B_SQ_MUL;
          end
        end
        B_SQRT: begin
          if (s >= trial) begin
            s  <= s - trial;
            rt <= (rt >> 1) + bitv;
          end else begin
            rt <= rt >> 1;
          end
          bitv <= bitv >> 2;
          if (bitv == 64'd1) state <= B_DIV_INIT;
        end
        B_DIV_INIT: begin
          rem   <= {2'b00, numer[58:30]};
          divq  <= numer[29:0];
          dcnt  <= '0;
          state <= B_DIV;
        end
        B_DIV: begin
          rem  <= div_ge ? div_d[30:0] : div_t[30:0];
          divq <= {divq[28:0], div_ge};
          dcnt <= dcnt + 5'd1;
          if (dcnt == 5'd29) state <= B_D_MUL;
        end
        B_D_MUL: begin
          prod  <= mul_a * mul_a;
          state <= B_D_ACC;
        end
        B_D_ACC: begin
          sum <= sum + 64'(prod);
          if (idx == 2'd2) begin
            state <= B_ERR;
          end else begin
            idx   <= idx + 2'd1;
            state <= B_DIV_INIT;
          end
        end
        B_ERR: begin
          err   <= 36'((sum + 64'h800_0000) >> 28);
          state <= B_DONE;
        end
        B_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid     <= 1'b1;
            is_inlier     <= inl;
            clipped_error <= clipped;
            inlier_count  <= cnt_sat;
            score_total   <= score_sat;
            pass_done     <= last;
            count_accum   <= last ? '0 : cnt_sat;
            score_accum   <= last ? '0 : score_sat;
            state         <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* hdl/absolute_bearing_inlier_score_unit.sv */
`default_nettype none
// channel  handshake                 payload
// in       in_valid / in_ready       bearing_x/y/z, point_x/y/z, last_pair
// out      out_valid / out_ready     is_inlier, clipped_error, inlier_count,
//                                    score_total, pass_done
// cfg      cfg_valid / cfg_ready     cfg_index, cfg_data (cfg_ready always high)
//
// Front: one shared 32x32 multiplier (rotation, R*p); takes no new item until
// it has pushed the last. Back: bit-serial normalize shift, the 32-step square
// root and three 30-step divisions; no new item until the result is registered.
// A two-beat queue sits between them; the output register frees the back.
// Synchronous reset clears control and running totals and sets config defaults.
module absolute_bearing_inlier_score_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] bearing_x,
  input  logic signed [15:0] bearing_y,
  input  logic signed [15:0] bearing_z,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] point_z,
  input  logic               last_pair,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               is_inlier,
  output logic [30:0]        clipped_error,
  output logic [16:0]        inlier_count,
  output logic [46:0]        score_total,
  output logic               pass_done,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import abis_pkg::*;

  pose_t       pose;
  logic [30:0] sq_threshold;
  item_t       f_item, b_item;
  logic        f_valid, f_ready, b_valid, b_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pose.quat_w  <= 16'sd16384;
      pose.quat_x  <= '0;
      pose.quat_y  <= '0;
      pose.quat_z  <= '0;
      pose.trans_x <= '0;
      pose.trans_y <= '0;
      pose.trans_z <= '0;
      sq_threshold <= 31'd262144;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_QUAT_W:  pose.quat_w  <= cfg_data[15:0];
        CFG_QUAT_X:  pose.quat_x  <= cfg_data[15:0];
        CFG_QUAT_Y:  pose.quat_y  <= cfg_data[15:0];
        CFG_QUAT_Z:  pose.quat_z  <= cfg_data[15:0];
        CFG_TRANS_X: pose.trans_x <= cfg_data;
        CFG_TRANS_Y: pose.trans_y <= cfg_data;
        CFG_TRANS_Z: pose.trans_z <= cfg_data;
        CFG_SQ_THR:  sq_threshold <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  abis_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .bearing_x  (bearing_x),
    .bearing_y  (bearing_y),
    .bearing_z  (bearing_z),
    .point_x    (point_x),
    .point_y    (point_y),
    .point_z    (point_z),
    .last_pair  (last_pair),
    .pose       (pose),
    .item       (f_item),
    .item_valid (f_valid),
    .item_ready (f_ready)
  );

  abis_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_item  (f_item),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .rd_item  (b_item),
    .rd_valid (b_valid),
    .rd_ready (b_ready)
  );

  abis_back u_back (
    .clk           (clk),
    .rst           (rst),
    .item          (b_item),
    .item_valid    (b_valid),
    .item_ready    (b_ready),
    .thr           (sq_threshold),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .is_inlier     (is_inlier),
    .clipped_error (clipped_error),
    .inlier_count  (inlier_count),
    .score_total   (score_total),
    .pass_done     (pass_done)
  );

endmodule
`default_nettype wire

/* sim/absolute_bearing_inlier_score_checker.sv */
`timescale 1ns / 100ps
module absolute_bearing_inlier_score_checker
  import abis_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [15:0] bearing_x,
  input  logic signed [15:0] bearing_y,
  input  logic signed [15:0] bearing_z,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] point_z,
  input  logic               last_pair,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic               is_inlier,
  input  logic [30:0]        clipped_error,
  input  logic [16:0]        inlier_count,
  input  logic [46:0]        score_total,
  input  logic               pass_done,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output int                 fail_count,
  output int                 pending
);

  typedef struct packed {
    logic        inl;
    logic [30:0] clip;
    logic [16:0] cnt;
    logic [46:0] score;
    logic        done;
  } score_t;

  score_t expected_scores[$];

  logic [15:0] qw, qx, qy, qz;
  logic [31:0] tx, ty, tz;
  logic [30:0] thr;
  logic [46:0] run_score;
  logic [16:0] run_count;

  assign pending = expected_scores.size();

  function automatic longint qclamp(logic [15:0] v);
    longint e;
    e = longint'($signed(v));
    if (e > 16384) return 16384;
    if (e < -16384) return -16384;
    return e;
  endfunction

  function automatic longint fshr(longint v, int k);
    return v >>> k;
  endfunction

  function automatic longint unsigned root64(longint unsigned s);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned pose_error(logic [15:0] bx, logic [15:0] by,
      logic [15:0] bz, logic [31:0] px, logic [31:0] py, logic [31:0] pz);
    longint w, x, y, z, acc, d, u;
    longint r[3][3];
    longint p[3], c[3], b[3], t[3];
    longint unsigned m, s, n, sum, q, mg;
    int k;
    w = qclamp(qw); x = qclamp(qx); y = qclamp(qy); z = qclamp(qz);
    r[0][0] = w*w + x*x - y*y - z*z; r[0][1] = 2*(x*y - w*z); r[0][2] = 2*(x*z + w*y);
    r[1][0] = 2*(x*y + w*z); r[1][1] = w*w - x*x + y*y - z*z; r[1][2] = 2*(y*z - w*x);
    r[2][0] = 2*(x*z - w*y); r[2][1] = 2*(y*z + w*x); r[2][2] = w*w - x*x - y*y + z*z;
    p[0] = longint'($signed(px)); p[1] = longint'($signed(py)); p[2] = longint'($signed(pz));
    t[0] = longint'($signed(tx)); t[1] = longint'($signed(ty)); t[2] = longint'($signed(tz));
    b[0] = longint'($signed(bx)); b[1] = longint'($signed(by)); b[2] = longint'($signed(bz));
    m = 0;
    for (int i = 0; i < 3; i++) begin
      acc = r[i][0]*p[0] + r[i][1]*p[1] + r[i][2]*p[2];
      c[i] = fshr(acc, 28) + t[i];
      mg = c[i] < 0 ? -c[i] : c[i];
      if (mg > m) m = mg;
    end
    // zero-length point scores as exactly the threshold
    if (m == 0) return thr;
    k = 0;
    while ((m >> k) >= (64'd1 << 30)) k++;
    if (k != 0) begin
      for (int i = 0; i < 3; i++) c[i] = fshr(c[i], k);
    end else begin
      while ((m << k) < (64'd1 << 29)) k++;
      for (int i = 0; i < 3; i++) c[i] = c[i] <<< k;
    end
    s = 0;
    for (int i = 0; i < 3; i++) s += c[i] * c[i];
    n = root64(s);
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      mg = c[i] < 0 ? -c[i] : c[i];
      q = ((mg << 28) + n / 2) / n;
      u = c[i] < 0 ? -longint'(q) : longint'(q);
      d = b[i] * 16384 - u;
      sum += d * d;
    end
    return (sum + (64'd1 << 27)) >> 28;
  endfunction

  task automatic report(string what, longint unsigned got, longint unsigned want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  always @(posedge clk) begin
    longint unsigned err, cnt, sc;
    score_t e;
    if (rst) begin
      qw <= 16'd16384; qx <= '0; qy <= '0; qz <= '0;
      tx <= '0; ty <= '0; tz <= '0;
      thr <= 31'd262144;
      run_score = '0;
      run_count = '0;
      fail_count = 0;
      expected_scores.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_QUAT_W:  qw <= cfg_data[15:0];
          CFG_QUAT_X:  qx <= cfg_data[15:0];
          CFG_QUAT_Y:  qy <= cfg_data[15:0];
          CFG_QUAT_Z:  qz <= cfg_data[15:0];
          CFG_TRANS_X: tx <= cfg_data;
          CFG_TRANS_Y: ty <= cfg_data;
          CFG_TRANS_Z: tz <= cfg_data;
          CFG_SQ_THR:  thr <= cfg_data[30:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        err = pose_error(bearing_x, bearing_y, bearing_z, point_x, point_y, point_z);
        e.inl = err < thr;
        e.clip = e.inl ? err[30:0] : thr;
        cnt = run_count + e.inl;
        if (cnt > COUNT_MAX) cnt = COUNT_MAX;
        sc = run_score + e.clip;
        if (sc > SCORE_MAX) sc = SCORE_MAX;
        e.cnt = cnt[16:0];
        e.score = sc[46:0];
        e.done = last_pair;
        expected_scores.push_back(e);
        run_count = last_pair ? '0 : cnt[16:0];
        run_score = last_pair ? '0 : sc[46:0];
      end
      if (out_valid && out_ready) begin
        if (expected_scores.size() == 0) begin
          report("unexpected beat", 1, 0);
        end else begin
          e = expected_scores.pop_front();
          if (is_inlier !== e.inl) report("is_inlier", is_inlier, e.inl);
          if (clipped_error !== e.clip) report("clipped_error", clipped_error, e.clip);
          if (inlier_count !== e.cnt) report("inlier_count", inlier_count, e.cnt);
          if (score_total !== e.score) report("score_total", score_total, e.score);
          if (pass_done !== e.done) report("pass_done", pass_done, e.done);
        end
      end
    end
  end

endmodule

/* sim/absolute_bearing_inlier_score_unit_tb.sv */
`timescale 1ns / 100ps
module absolute_bearing_inlier_score_unit_tb;
  import abis_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0, out_ready = 1'b0, cfg_valid = 1'b0;
  logic in_ready, out_valid, cfg_ready;
  logic signed [15:0] bearing_x = '0, bearing_y = '0, bearing_z = '0;
  logic signed [31:0] point_x = '0, point_y = '0, point_z = '0;
  logic last_pair = 1'b0;
  logic is_inlier, pass_done;
  logic [30:0] clipped_error;
  logic [16:0] inlier_count;
  logic [46:0] score_total;
  logic [2:0] cfg_index = CFG_QUAT_W;
  logic [31:0] cfg_data = '0;
  int fail_count, pending;
  int cycle_count = 0;
  bit hold_off = 1'b0;

  localparam int CYCLE_LIMIT = 3000000;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  absolute_bearing_inlier_score_unit uut (.*);
  absolute_bearing_inlier_score_checker chk (.*);

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 400);
  endfunction

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver: random stalls, and one long hold-off to back up the block
  initial begin
    int g;
    @(negedge clk);
    while (1) begin
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (6000) @(negedge clk);
        hold_off = 1'b0;
      end
      g = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
      if (g > 0) begin
        out_ready <= 1'b0;
        repeat (g) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(negedge clk);
    end
  end

  task automatic cfg_write(logic [2:0] idx, logic [31:0] v);
    cfg_index <= idx;
    cfg_data <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_pair(logic [15:0] bx, logic [15:0] by, logic [15:0] bz,
      logic [31:0] px, logic [31:0] py, logic [31:0] pz, logic lst);
    int g;
    g = ($urandom_range(0, 2) == 0) ? gap_len() : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    bearing_x <= bx; bearing_y <= by; bearing_z <= bz;
    point_x <= px; point_y <= py; point_z <= pz;
    last_pair <= lst;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (400) @(negedge clk);
  endtask

  function automatic logic [15:0] rand_q();
    case ($urandom_range(0, 5))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'(-$urandom_range(0, 16384));
      3: return $urandom();
      default: return 16'($urandom_range(0, 16384));
    endcase
  endfunction

  function automatic logic [31:0] rand_p();
    case ($urandom_range(0, 4))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom();
      3: return 32'($signed($urandom_range(0, 4000)) - 2000);
      default: return 32'($signed($urandom_range(0, 2000000)) - 1000000) <<< 4;
    endcase
  endfunction

  // unit rotation by a random angle about one axis
  task automatic rand_pose();
    real a;
    int ax;
    a = $urandom_range(0, 6283) / 2000.0;
    ax = $urandom_range(0, 2);
    cfg_write(CFG_QUAT_W, 32'($rtoi($cos(a) * 16384.0)));
    cfg_write(CFG_QUAT_X, ax == 0 ? 32'($rtoi($sin(a) * 16384.0)) : 32'd0);
    cfg_write(CFG_QUAT_Y, ax == 1 ? 32'($rtoi($sin(a) * 16384.0)) : 32'd0);
    cfg_write(CFG_QUAT_Z, ax == 2 ? 32'($rtoi($sin(a) * 16384.0)) : 32'd0);
    cfg_write(CFG_TRANS_X, rand_p());
    cfg_write(CFG_TRANS_Y, rand_p());
    cfg_write(CFG_TRANS_Z, 32'($urandom_range(65536, 65536 * 50)));
    cfg_write(CFG_SQ_THR, $urandom_range(0, 3) == 0 ? 32'h4000_0000 :
                          32'($urandom_range(0, 4000000)));
  endtask

  initial begin
    logic [15:0] b0, b1, b2;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: default pose
    send_pair(16'sd0, 16'sd0, 16'sd16384, 32'sd0, 32'sd0, 32'sd65536, 1'b0);
    send_pair(16'sd0, 16'sd0, 16'sd0, 32'sd0, 32'sd0, 32'sd0, 1'b0);
    send_pair(16'h7FFF, 16'h8000, 16'sd16384, 32'h7FFF_FFFF, 32'h8000_0000,
              32'h7FFF_FFFF, 1'b0);
    send_pair(-16'sd16384, 16'sd16384, -16'sd16384, 32'h8000_0000, 32'h8000_0000,
              32'h8000_0000, 1'b0);
    send_pair(16'sd16384, 16'sd0, 16'sd0, 32'sd1, 32'sd0, 32'sd0, 1'b1);
    send_pair(16'sd0, 16'sd16384, 16'sd0, 32'sd0, 32'sd3, -32'sd1, 1'b1);
    drain();

    // out-of-range, non-unit quaternion and extreme translation/threshold
    cfg_write(CFG_QUAT_W, 32'h0000_7FFF);
    cfg_write(CFG_QUAT_X, 32'h0000_8000);
    cfg_write(CFG_QUAT_Y, 32'h0000_2000);
    cfg_write(CFG_QUAT_Z, 32'hFFFF_C000);
    cfg_write(CFG_TRANS_X, 32'h7FFF_FFFF);
    cfg_write(CFG_TRANS_Y, 32'h8000_0000);
    cfg_write(CFG_TRANS_Z, 32'h0001_0000);
    cfg_write(CFG_SQ_THR, 32'h7FFF_FFFF);
    send_pair(16'sd0, 16'sd0, 16'sd0, 32'sd0, 32'sd0, 32'sd0, 1'b0);
    send_pair(16'hFFFF, 16'h0000, 16'h7FFF, 32'hFFFF_FFFF, 32'sd5, 32'sd0, 1'b1);
    drain();
    cfg_write(CFG_QUAT_W, 32'd0);
    cfg_write(CFG_QUAT_X, 32'd0);
    cfg_write(CFG_QUAT_Y, 32'd0);
    cfg_write(CFG_QUAT_Z, 32'd0);
    cfg_write(CFG_TRANS_X, 32'd0);
    cfg_write(CFG_TRANS_Y, 32'd0);
    cfg_write(CFG_TRANS_Z, 32'd0);
    cfg_write(CFG_SQ_THR, 32'd0);
    // all-zero rotation: every point is zero-length
    send_pair(16'sd16384, 16'sd0, 16'sd0, 32'sd99, 32'sd7, 32'sd1, 1'b0);
    send_pair(16'sd0, 16'sd0, 16'sd0, 32'sd0, 32'sd0, 32'sd0, 1'b1);
    drain();

    // random phases; long receiver hold-off in the first one
    for (int ph = 0; ph < 12; ph++) begin
      rand_pose();
      if (ph == 0) hold_off = 1'b1;
      for (int n = 0; n < 78; n++) begin
        if ($urandom_range(0, 9) < 7) begin
          // bearing taken from the point for mostly near-inliers
          b0 = $urandom_range(0, 1) ? 16'($urandom_range(0, 16384)) : 16'(-$urandom_range(0, 16384));
          b1 = $urandom_range(0, 1) ? 16'($urandom_range(0, 2000)) : 16'(-$urandom_range(0, 2000));
          b2 = 16'($urandom_range(14000, 16384));
          send_pair(b0, b1, b2, 32'(b0) <<< 4, 32'(b1) <<< 4,
                    32'(b2) <<< 4, $urandom_range(0, 15) == 0);
        end else begin
          send_pair($urandom(), $urandom(), $urandom(), rand_p(), rand_p(), rand_p(),
                    $urandom_range(0, 15) == 0);
        end
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
